@@ rtl/gra_pkg.sv @@
`timescale 1ns / 1ps

package gra_pkg;

    // Fixed field widths of the request, result and register channels
    localparam int CMD_W       = 1;
    localparam int POS_W       = 5;
    localparam int EXT_W       = 6;
    localparam int HEIGHT_W    = 8;
    localparam int GRID_W      = 6;
    localparam int FREE_W      = 11;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    // Corner plus extent: 31 + 63 fits in seven bits
    localparam int END_W = 7;

    localparam logic [CMD_W-1:0] CMD_PLACE = 1'b0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 1'b1;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t CFG_GRID_LENGTH  = 2'd0;
    localparam cfg_index_t CFG_GRID_WIDTH   = 2'd1;
    localparam cfg_index_t CFG_HEIGHT_LIMIT = 2'd2;

    localparam logic [GRID_W-1:0]   GRID_LENGTH_RST  = 6'd32;
    localparam logic [GRID_W-1:0]   GRID_WIDTH_RST   = 6'd32;
    localparam logic [HEIGHT_W-1:0] HEIGHT_LIMIT_RST = 8'd255;

    // Operations of the shared row unit
    typedef enum logic [1:0] {
        ROW_CHECK,
        ROW_SET,
        ROW_CLEAR,
        ROW_COUNT
    } row_op_t;

    // Row unit results handed back to the sequencer
    typedef struct packed {
        logic hit;
    } row_status_t;

endpackage

@@ rtl/gra_row_store.sv @@
`timescale 1ns / 1ps

module gra_row_store #(
    parameter int DEPTH  = 32,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 5
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_q_reg;
    logic [DEPTH-1:0] row_valid_reg;
    logic             rd_valid_reg;

    // A row never written since reset reads as all free
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end else begin
            if (wr_en) begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= row_valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_q_reg : '0;

endmodule

@@ rtl/gra_row_unit.sv @@
`timescale 1ns / 1ps

module gra_row_unit #(
    parameter int WIDTH = 32,
    parameter int POP_W = 6
) (
    input  gra_pkg::row_op_t     op,
    input  logic [WIDTH-1:0]     row,
    input  logic [WIDTH-1:0]     rect_mask,
    input  logic [WIDTH-1:0]     col_mask,
    output logic [WIDTH-1:0]     new_row,
    output gra_pkg::row_status_t status,
    output logic [POP_W-1:0]     free_bits
);

    import gra_pkg::*;

    logic [WIDTH-1:0] avail;

    always_comb begin
        case (op)
            ROW_SET:   new_row = row | rect_mask;
            ROW_CLEAR: new_row = row & ~rect_mask;
            default:   new_row = row;
        endcase
    end

    assign status.hit = |(row & rect_mask);

    // Free cells of the active columns in this row
    assign avail = ~row & col_mask;

    always_comb begin
        free_bits = '0;
        for (int j = 0; j < WIDTH; j++) begin
            free_bits = free_bits + POP_W'(avail[j]);
        end
    end

endmodule

@@ rtl/grid_rectangle_allocator.sv @@
`timescale 1ns / 1ps

// Grid rectangle allocator. Keeps one occupancy bit per cell of a MAX_LENGTH by
// MAX_WIDTH grid, all free after reset, stored as one memory row per position
// along the length axis. A place request (command 0) succeeds only if the
// rectangle fits inside the active grid (grid_length by grid_width, each capped
// at its maximum), its height is within height_limit and every covered cell is
// free; it then marks the cells occupied. A clear request (command 1) frees the
// covered cells that lie inside the active grid and always reports success.
// Every result carries the free-cell count of the active grid after the request.
// One request is in work at a time: s_ready is high only while the sequencer is
// idle, and a finished result waits in the output register so the next request
// can be taken meanwhile. All work is done by one row unit fed from the single
// memory read port, each row being read and then evaluated or written back. A
// successful place runs a check pass, a mark pass and a count pass; a place
// that hits an occupied cell ends its check pass there and goes on to the count
// pass; a place rejected by the bounds or height test runs the count pass only;
// and a clear runs a clear pass over its covered active rows, then the count pass.
// Configuration writes are taken in any cycle and must only be issued while the
// block is idle.
module grid_rectangle_allocator #(
    parameter int MAX_LENGTH = 32,
    parameter int MAX_WIDTH  = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [gra_pkg::CMD_W-1:0]         s_command,
    input  logic [gra_pkg::POS_W-1:0]         s_pos_x,
    input  logic [gra_pkg::POS_W-1:0]         s_pos_y,
    input  logic [gra_pkg::EXT_W-1:0]         s_rect_length,
    input  logic [gra_pkg::EXT_W-1:0]         s_rect_width,
    input  logic [gra_pkg::HEIGHT_W-1:0]      s_rect_height,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_placed_ok,
    output logic [gra_pkg::FREE_W-1:0]        m_free_count,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  gra_pkg::cfg_index_t               cfg_index,
    input  logic [gra_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import gra_pkg::*;

    localparam int ADDR_W = $clog2(MAX_LENGTH);
    // Row counter must hold both a corner-plus-extent sum and the row count
    localparam int CNT_W  = (ADDR_W + 1 > END_W) ? ADDR_W + 1 : END_W;
    localparam int POP_W  = $clog2(MAX_WIDTH + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHK_RD,
        ST_CHK_EV,
        ST_MRK_RD,
        ST_MRK_WR,
        ST_CLR_RD,
        ST_CLR_WR,
        ST_CNT_RD,
        ST_CNT_EV,
        ST_DONE
    } state_t;

    // Configuration registers
    logic [GRID_W-1:0]   grid_length_reg;
    logic [GRID_W-1:0]   grid_width_reg;
    logic [HEIGHT_W-1:0] height_limit_reg;

    // Sequencer state and working registers
    state_t               state_reg,        state_next;
    logic [CNT_W-1:0]     row_cnt_reg,      row_cnt_next;
    logic [CNT_W-1:0]     row_end_reg,      row_end_next;
    logic [POS_W-1:0]     pos_x_reg,        pos_x_next;
    logic [MAX_WIDTH-1:0] rect_mask_reg,    rect_mask_next;
    logic [MAX_WIDTH-1:0] col_mask_reg,     col_mask_next;
    logic                 ok_reg,           ok_next;
    logic [FREE_W-1:0]    acc_reg,          acc_next;
    logic                 m_valid_reg,      m_valid_next;
    logic                 m_placed_ok_reg,  m_placed_ok_next;
    logic [FREE_W-1:0]    m_free_count_reg, m_free_count_next;

    // Active grid, with oversized registers capped at the maximum
    logic [GRID_W-1:0] act_length;
    logic [GRID_W-1:0] act_width;
    logic [END_W-1:0]  x_end;
    logic [END_W-1:0]  y_end;
    logic              bounds_ok;
    logic [END_W-1:0]  clear_end;
    logic [MAX_WIDTH-1:0] req_rect_mask;
    logic [MAX_WIDTH-1:0] req_col_mask;

    // Row store and row unit connections
    logic                 rd_en;
    logic                 wr_en;
    logic [ADDR_W-1:0]    row_addr;
    logic [MAX_WIDTH-1:0] rd_data;
    logic [MAX_WIDTH-1:0] new_row;
    row_op_t              row_op;
    row_status_t          row_status;
    logic [POP_W-1:0]     free_bits;

    assign act_length = (int'(grid_length_reg) > MAX_LENGTH) ? GRID_W'(MAX_LENGTH)
                                                             : grid_length_reg;
    assign act_width  = (int'(grid_width_reg) > MAX_WIDTH) ? GRID_W'(MAX_WIDTH)
                                                           : grid_width_reg;

    assign x_end = END_W'(s_pos_x) + END_W'(s_rect_length);
    assign y_end = END_W'(s_pos_y) + END_W'(s_rect_width);

    assign bounds_ok = (x_end <= END_W'(act_length)) &&
                       (y_end <= END_W'(act_width))  &&
                       (s_rect_height <= height_limit_reg);

    // Clear stops at the edge of the active grid
    assign clear_end = (x_end < END_W'(act_length)) ? x_end : END_W'(act_length);

    // Column masks: covered columns inside the active width, and all active columns
    always_comb begin
        for (int j = 0; j < MAX_WIDTH; j++) begin
            req_rect_mask[j] = (j >= int'(s_pos_y)) && (j < int'(y_end)) &&
                               (j < int'(act_width));
            req_col_mask[j]  = (j < int'(act_width));
        end
    end

    // Configuration writes; an index past the register list is dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_length_reg  <= GRID_LENGTH_RST;
            grid_width_reg   <= GRID_WIDTH_RST;
            height_limit_reg <= HEIGHT_LIMIT_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_GRID_LENGTH:  grid_length_reg  <= cfg_data[GRID_W-1:0];
                CFG_GRID_WIDTH:   grid_width_reg   <= cfg_data[GRID_W-1:0];
                CFG_HEIGHT_LIMIT: height_limit_reg <= cfg_data[HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // Memory access follows the sequencer: read in the *_RD states, write back
    // the modified row in the *_WR states at the same row.
    assign rd_en    = state_reg inside {ST_CHK_RD, ST_MRK_RD, ST_CLR_RD, ST_CNT_RD};
    assign wr_en    = state_reg inside {ST_MRK_WR, ST_CLR_WR};
    assign row_addr = row_cnt_reg[ADDR_W-1:0];

    always_comb begin
        case (state_reg)
            ST_CHK_EV: row_op = ROW_CHECK;
            ST_MRK_WR: row_op = ROW_SET;
            ST_CLR_WR: row_op = ROW_CLEAR;
            default:   row_op = ROW_COUNT;
        endcase
    end

    gra_row_store #(
        .DEPTH  (MAX_LENGTH),
        .WIDTH  (MAX_WIDTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (rd_en),
        .rd_addr (row_addr),
        .wr_en   (wr_en),
        .wr_addr (row_addr),
        .wr_data (new_row),
        .rd_data (rd_data)
    );

    gra_row_unit #(
        .WIDTH (MAX_WIDTH),
        .POP_W (POP_W)
    ) u_row (
        .op        (row_op),
        .row       (rd_data),
        .rect_mask (rect_mask_reg),
        .col_mask  (col_mask_reg),
        .new_row   (new_row),
        .status    (row_status),
        .free_bits (free_bits)
    );

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next        = state_reg;
        row_cnt_next      = row_cnt_reg;
        row_end_next      = row_end_reg;
        pos_x_next        = pos_x_reg;
        rect_mask_next    = rect_mask_reg;
        col_mask_next     = col_mask_reg;
        ok_next           = ok_reg;
        acc_next          = acc_reg;
        m_valid_next      = m_valid_reg;
        m_placed_ok_next  = m_placed_ok_reg;
        m_free_count_next = m_free_count_reg;

        // Drop the result once the consumer takes it
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    pos_x_next     = s_pos_x;
                    rect_mask_next = req_rect_mask;
                    col_mask_next  = req_col_mask;
                    row_cnt_next   = CNT_W'(s_pos_x);
                    if (s_command == CMD_PLACE) begin
                        if (bounds_ok) begin
                            row_end_next = CNT_W'(x_end);
                            state_next   = ST_CHK_RD;
                        end else begin
                            ok_next      = 1'b0;
                            row_cnt_next = '0;
                            acc_next     = '0;
                            state_next   = ST_CNT_RD;
                        end
                    end else begin
                        row_end_next = CNT_W'(clear_end);
                        state_next   = ST_CLR_RD;
                    end
                end
            end
            ST_CHK_RD: begin
                if (row_cnt_reg >= row_end_reg) begin
                    row_cnt_next = CNT_W'(pos_x_reg);
                    state_next   = ST_MRK_RD;
                end else begin
                    state_next = ST_CHK_EV;
                end
            end
            ST_CHK_EV: begin
                if (row_status.hit) begin
                    ok_next      = 1'b0;
                    row_cnt_next = '0;
                    acc_next     = '0;
                    state_next   = ST_CNT_RD;
                end else begin
                    row_cnt_next = row_cnt_reg + CNT_W'(1);
                    state_next   = ST_CHK_RD;
                end
            end
            ST_MRK_RD: begin
                if (row_cnt_reg >= row_end_reg) begin
                    ok_next      = 1'b1;
                    row_cnt_next = '0;
                    acc_next     = '0;
                    state_next   = ST_CNT_RD;
                end else begin
                    state_next = ST_MRK_WR;
                end
            end
            ST_MRK_WR: begin
                row_cnt_next = row_cnt_reg + CNT_W'(1);
                state_next   = ST_MRK_RD;
            end
            ST_CLR_RD: begin
                if (row_cnt_reg >= row_end_reg) begin
                    ok_next      = 1'b1;
                    row_cnt_next = '0;
                    acc_next     = '0;
                    state_next   = ST_CNT_RD;
                end else begin
                    state_next = ST_CLR_WR;
                end
            end
            ST_CLR_WR: begin
                row_cnt_next = row_cnt_reg + CNT_W'(1);
                state_next   = ST_CLR_RD;
            end
            ST_CNT_RD: begin
                if (row_cnt_reg >= CNT_W'(act_length)) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_CNT_EV;
                end
            end
            ST_CNT_EV: begin
                // Count wraps at the result width
                acc_next     = acc_reg + FREE_W'(free_bits);
                row_cnt_next = row_cnt_reg + CNT_W'(1);
                state_next   = ST_CNT_RD;
            end
            ST_DONE: begin
                // Hold here until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next      = 1'b1;
                    m_placed_ok_next  = ok_reg;
                    m_free_count_next = acc_reg;
                    state_next        = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        row_cnt_reg      <= row_cnt_next;
        row_end_reg      <= row_end_next;
        pos_x_reg        <= pos_x_next;
        rect_mask_reg    <= rect_mask_next;
        col_mask_reg     <= col_mask_next;
        ok_reg           <= ok_next;
        acc_reg          <= acc_next;
        m_placed_ok_reg  <= m_placed_ok_next;
        m_free_count_reg <= m_free_count_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_placed_ok  = m_placed_ok_reg;
    assign m_free_count = m_free_count_reg;

endmodule

@@ rtl/gra_checker.sv @@
`timescale 1ns / 1ps

module gra_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic [gra_pkg::CMD_W-1:0]      s_command,
    input logic [gra_pkg::POS_W-1:0]      s_pos_x,
    input logic [gra_pkg::POS_W-1:0]      s_pos_y,
    input logic [gra_pkg::EXT_W-1:0]      s_rect_length,
    input logic [gra_pkg::EXT_W-1:0]      s_rect_width,
    input logic [gra_pkg::HEIGHT_W-1:0]   s_rect_height,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic                           m_placed_ok,
    input logic [gra_pkg::FREE_W-1:0]     m_free_count
);

    import gra_pkg::*;

    logic       in_acc;
    logic       out_acc;
    logic [1:0] pend_reg, pend_next;

    assign in_acc  = s_valid && s_ready;
    assign out_acc = m_valid && m_ready;

    // Track requests taken but not yet answered
    assign pend_next = pend_reg + 2'(in_acc) - 2'(out_acc);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    // One request in work at a time: busy right after a request is taken
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |=> !s_ready)
        else $error("s_ready high in the cycle after a request was taken");

    // No result without a request behind it
    a_no_spurious_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (pend_reg != 2'd0))
        else $error("result shown with no request outstanding");

    // At most one request in work plus one result waiting
    a_pending_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg != 2'd3)
        else $error("more than two requests outstanding");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
            (m_valid && $stable(m_placed_ok) && $stable(m_free_count)))
        else $error("stalled result changed or dropped");

    // A waiting request holds its payload until taken
    a_request_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && !s_ready) |=>
            (s_valid && $stable(s_command) && $stable(s_pos_x) && $stable(s_pos_y) &&
             $stable(s_rect_length) && $stable(s_rect_width) && $stable(s_rect_height)))
        else $error("waiting request changed or dropped");

endmodule

bind grid_rectangle_allocator gra_checker u_gra_checker (.*);
